// ===== hw/rtl/srat_pkg.sv =====
// ----------------------------------------------------------------------------
// srat_pkg: section range address translator shared types
// Item layouts, opcodes and table sizing used by the cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package srat_pkg;

	// number of section entries, one cell each
	localparam int MAX_SECTIONS = 16;

	// width that holds any cell number and the section count register
	localparam int CELL_W = $clog2(MAX_SECTIONS + 1);
	localparam int CMP_W  = (CELL_W > 5) ? CELL_W : 5;

	localparam int OFF_W   = 32;
	localparam int COUNT_W = 5;
	localparam int IDX_W   = 4;

	// opcodes; the fourth code means nothing and is dropped on entry
	localparam logic [1:0] OP_LOAD        = 2'd0;
	localparam logic [1:0] OP_MEM_TO_FILE = 2'd1;
	localparam logic [1:0] OP_FILE_TO_MEM = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] entry_index;
		logic [OFF_W-1:0] entry_mem_base;
		logic [OFF_W-1:0] entry_size;
		logic [OFF_W-1:0] entry_file_base;
		logic [OFF_W-1:0] offset_in;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset_out;
		logic             hit;
		logic [IDX_W-1:0] matched_entry;
	} rsp_t;

	// item travelling along the cell chain
	typedef struct packed {
		logic             valid;
		req_t             req;
		logic [OFF_W-1:0] result;
		logic             hit;
		logic [IDX_W-1:0] match;
	} slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srat_cell.sv =====
// ----------------------------------------------------------------------------
// srat_cell: one section entry of the translator chain
// Holds one entry, writes it when a load for it passes, and checks passing
// translate items against its range before handing them on.
// ----------------------------------------------------------------------------
`default_nettype none

module srat_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          advance,
	input  wire [srat_pkg::CMP_W-1:0]    cell_idx,
	input  wire [srat_pkg::COUNT_W-1:0]  section_count,
	input  wire srat_pkg::slot_t         up,
	output srat_pkg::slot_t              dn
);

	// entry storage, valid only once written
	logic [srat_pkg::OFF_W-1:0] mem_base_q;
	logic [srat_pkg::OFF_W-1:0] file_base_q;
	logic [srat_pkg::OFF_W:0]   mem_top_q;
	logic [srat_pkg::OFF_W:0]   file_top_q;
	logic [srat_pkg::OFF_W-1:0] delta_q;

	logic                       valid_s1;
	srat_pkg::slot_t            data_s1;
	srat_pkg::slot_t            nxt;

	logic                       active;
	logic                       load_here;
	logic                       in_mem;
	logic                       in_file;
	logic [srat_pkg::OFF_W:0]   off_ext;

	assign active    = cell_idx < srat_pkg::CMP_W'(section_count);
	assign load_here = advance && up.valid && (up.req.opcode == srat_pkg::OP_LOAD)
		&& (srat_pkg::CMP_W'(up.req.entry_index) == cell_idx);

	assign off_ext = {1'b0, up.req.offset_in};
	assign in_mem  = (mem_base_q <= up.req.offset_in) && (off_ext <= mem_top_q);
	assign in_file = (file_base_q <= up.req.offset_in) && (off_ext <= file_top_q);

	always_comb begin
		nxt = up;
		if (up.valid && active && !up.hit) begin
			case (up.req.opcode)
				srat_pkg::OP_MEM_TO_FILE: begin
					if (in_mem) begin
						nxt.result = up.req.offset_in + delta_q;
						nxt.hit    = 1'b1;
						nxt.match  = cell_idx[srat_pkg::IDX_W-1:0];
					end
				end
				srat_pkg::OP_FILE_TO_MEM: begin
					if (in_file) begin
						nxt.result = up.req.offset_in - delta_q;
						nxt.hit    = 1'b1;
						nxt.match  = cell_idx[srat_pkg::IDX_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// precompute range tops and rebase delta as the entry is written
	always_ff @(posedge clk) begin
		if (load_here) begin
			mem_base_q  <= up.req.entry_mem_base;
			file_base_q <= up.req.entry_file_base;
			mem_top_q   <= {1'b0, up.req.entry_mem_base} + {1'b0, up.req.entry_size};
			file_top_q  <= {1'b0, up.req.entry_file_base} + {1'b0, up.req.entry_size};
			delta_q     <= up.req.entry_file_base - up.req.entry_mem_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= nxt;
		end
	end

	always_comb begin
		dn       = data_s1;
		dn.valid = valid_s1;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/section_range_address_translator.sv =====
// ----------------------------------------------------------------------------
// section_range_address_translator: section table offset translation
// Chain of section cells that rebases offsets between memory and file space.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall / req_item) takes load and
//   translate items. A load writes one section entry and gives no result;
//   a translate item (memory to file, or file to memory) gives one result
//   on the response channel (rsp_valid / rsp_stall / rsp_item). Items with
//   the unused opcode are taken and dropped.
//   Each item walks a row of MAX_SECTIONS cells, one cell per cycle unless
//   the chain is frozen; cell k holds entry k and either writes it (load)
//   or checks the offset against its range (translate). The first matching
//   cell below section_count claims the item; later cells pass it on
//   untouched. The row takes one item per cycle while unstalled, as the chain
//   moves one cell per cycle and loads travel in order with translates.
//   section_count is written through cfg_wr_en / cfg_wr_data; the user
//   must do so only while idle, as the block does not enforce it.
//   Reset clears the chain, the response register and section_count; the
//   entries themselves are undefined until loaded.
//   When rsp_stall holds a waiting result, the whole chain freezes and
//   req_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module section_range_address_translator (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           req_valid,
	output logic                          req_stall,
	input  wire srat_pkg::req_t           req_item,
	output logic                          rsp_valid,
	input  wire                           rsp_stall,
	output srat_pkg::rsp_t                rsp_item,
	input  wire                           cfg_wr_en,
	input  wire [srat_pkg::COUNT_W-1:0]   cfg_wr_data
);

	logic [srat_pkg::COUNT_W-1:0] count_q;
	logic                         rsp_valid_q;
	srat_pkg::rsp_t               rsp_q;
	logic                         advance;
	srat_pkg::slot_t              chain [srat_pkg::MAX_SECTIONS+1];
	srat_pkg::slot_t              tail;
	logic                         tail_rsp;

	// advance the whole row whenever the response register can take an item
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !advance;

	// inject at the head; drop the unused opcode here
	always_comb begin
		chain[0].valid  = req_valid && advance && (req_item.opcode == srat_pkg::OP_LOAD
			|| req_item.opcode == srat_pkg::OP_MEM_TO_FILE
			|| req_item.opcode == srat_pkg::OP_FILE_TO_MEM);
		chain[0].req    = req_item;
		chain[0].result = req_item.offset_in;
		chain[0].hit    = 1'b0;
		chain[0].match  = '0;
	end

	for (genvar k = 0; k < srat_pkg::MAX_SECTIONS; k++) begin : g_cell
		srat_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.cell_idx      (srat_pkg::CMP_W'(k)),
			.section_count (count_q),
			.up            (chain[k]),
			.dn            (chain[k+1])
		);
	end

	assign tail     = chain[srat_pkg::MAX_SECTIONS];
	// loads leave the row here; only translates produce a result
	assign tail_rsp = tail.valid && (tail.req.opcode != srat_pkg::OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= tail_rsp;
		end
	end

	// hold the result while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.offset_out    <= tail.result;
			rsp_q.hit           <= tail.hit;
			rsp_q.matched_entry <= tail.match;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srat_checker.sv =====
// ----------------------------------------------------------------------------
// srat_checker: port-level checks for the section range address translator
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srat_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_stall,
	input wire                          rsp_valid,
	input wire                          rsp_stall,
	input wire srat_pkg::rsp_t          rsp_item
);

	// a stalled result stays and holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("response changed while stalled");

	// a miss reports entry zero
	a_miss_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.hit |-> rsp_item.matched_entry == '0)
		else $error("miss with non-zero matched entry");

	// a held result freezes the row, so no item may enter
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response stalled");

	// with the response side free the row always moves
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with free response register");

endmodule

bind section_range_address_translator srat_checker u_srat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);

`default_nettype wire

// ===== tb/tb_section_range_address_translator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_section_range_address_translator: self-checking bench for the translator
// Drives loads and translate items through the request channel with random
// gaps and stalls. A scoreboard keeps its own section table and predicts every
// result, and it compares each response field by field in arrival order.
// ----------------------------------------------------------------------------

// Shadow section table plus the queue of translations still owed by the block
class section_scoreboard;
	logic [31:0]           mem_base [srat_pkg::MAX_SECTIONS];
	logic [31:0]           sect_size [srat_pkg::MAX_SECTIONS];
	logic [31:0]           file_base [srat_pkg::MAX_SECTIONS];
	logic [4:0]            section_count;
	srat_pkg::rsp_t        owed [$];
	int unsigned           errors;

	function new();
		for (int i = 0; i < srat_pkg::MAX_SECTIONS; i++) begin
			mem_base[i]  = '0;
			sect_size[i] = '0;
			file_base[i] = '0;
		end
		section_count = '0;
		errors        = 0;
	endfunction

	// rebase an offset through the first section whose inclusive range holds it
	function srat_pkg::rsp_t translate(srat_pkg::req_t r);
		srat_pkg::rsp_t res;
		int             lim;
		logic [31:0]    src;
		logic [31:0]    dst;
		logic [32:0]    top;
		res.offset_out    = r.offset_in;
		res.hit           = 1'b0;
		res.matched_entry = '0;
		lim = (section_count > srat_pkg::MAX_SECTIONS) ? srat_pkg::MAX_SECTIONS
			: section_count;
		for (int i = 0; i < lim; i++) begin
			src = (r.opcode == srat_pkg::OP_MEM_TO_FILE) ? mem_base[i] : file_base[i];
			dst = (r.opcode == srat_pkg::OP_MEM_TO_FILE) ? file_base[i] : mem_base[i];
			top = {1'b0, src} + {1'b0, sect_size[i]};
			if (r.offset_in >= src && {1'b0, r.offset_in} <= top) begin
				res.offset_out    = r.offset_in - src + dst;
				res.hit           = 1'b1;
				res.matched_entry = i[srat_pkg::IDX_W-1:0];
				break;
			end
		end
		return res;
	endfunction

	// note an accepted item: update the table or queue the translation owed
	function void note_item(srat_pkg::req_t r);
		case (r.opcode) inside
			srat_pkg::OP_LOAD: begin
				if (r.entry_index < srat_pkg::MAX_SECTIONS) begin
					mem_base[r.entry_index]  = r.entry_mem_base;
					sect_size[r.entry_index] = r.entry_size;
					file_base[r.entry_index] = r.entry_file_base;
				end
			end
			srat_pkg::OP_MEM_TO_FILE, srat_pkg::OP_FILE_TO_MEM: begin
				owed.push_back(translate(r));
			end
			default: begin
			end
		endcase
	endfunction

	task report(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_result(srat_pkg::rsp_t got);
		srat_pkg::rsp_t want;
		if (owed.size() == 0) begin
			report($sformatf("result %h with nothing owed", got));
			return;
		end
		want = owed.pop_front();
		if (got.offset_out !== want.offset_out)
			report($sformatf("offset_out %h, want %h", got.offset_out, want.offset_out));
		if (got.hit !== want.hit)
			report($sformatf("hit %b, want %b", got.hit, want.hit));
		if (got.matched_entry !== want.matched_entry)
			report($sformatf("matched_entry %0d, want %0d", got.matched_entry,
				want.matched_entry));
	endtask
endclass

module tb_section_range_address_translator;

	// opcode the block takes and drops without a result
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// number of cells in the chain, used to let trailing loads walk out of it
	localparam int LATENCY   = srat_pkg::MAX_SECTIONS;
	localparam int LONG_HOLD = 80;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          req_valid   = 1'b0;
	logic                          req_stall;
	srat_pkg::req_t                req_item    = '0;
	logic                          rsp_valid;
	logic                          rsp_stall   = 1'b0;
	srat_pkg::rsp_t                rsp_item;
	logic                          cfg_wr_en   = 1'b0;
	logic [srat_pkg::COUNT_W-1:0]  cfg_wr_data = '0;

	section_scoreboard sb = new();

	// quiet: no gaps and no stalls on either side
	bit quiet        = 1'b0;
	// long receiver hold-off requested by the stimulus, counted by the receiver
	int hold_request = 0;

	int phase_count [8] = '{16, 31, 0, 17, 8, 2, 16, 31};

	section_range_address_translator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_item    (req_item),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_item    (rsp_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	// Receiver: decide the stall at each rising edge. A long hold-off runs first,
	// then any burst in progress, else now and then start a fresh stall burst.
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Sample responses on the falling edge, away from the driving edge: the values seen
	// here are those the next rising edge will act on.
	always @(negedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp_item);
	end

	// Present one item from a rising edge and hold it until it is taken.
	// Leave the process on the edge that accepts it.
	task automatic send_item(input srat_pkg::req_t r);
		req_valid <= 1'b1;
		req_item  <= r;
		do
			@(negedge clk);
		while (req_stall);
		sb.note_item(r);
		@(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Send with the odd random gap in front, unless quiet.
	task automatic offer(input srat_pkg::req_t r);
		if (!quiet && $urandom_range(0, 4) == 0)
			pause_sender($urandom_range(1, 6));
		send_item(r);
	endtask

	// Stop sending until every owed result has come back, then let trailing
	// loads walk out of the chain.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	// Change the section count only with the chain empty.
	task automatic write_section_count(input logic [srat_pkg::COUNT_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en        <= 1'b0;
		sb.section_count  = value;
	endtask

	function automatic srat_pkg::req_t pack_item(input logic [1:0] op,
			input logic [3:0] idx, input logic [31:0] mb, input logic [31:0] sz,
			input logic [31:0] fb, input logic [31:0] off);
		srat_pkg::req_t r;
		r.opcode          = op;
		r.entry_index     = idx;
		r.entry_mem_base  = mb;
		r.entry_size      = sz;
		r.entry_file_base = fb;
		r.offset_in       = off;
		return r;
	endfunction

	// Section load with mostly small sizes so that ranges stay distinct, and the
	// odd base near the top of the space, empty section or full-span size.
	function automatic srat_pkg::req_t random_load(input logic [3:0] idx);
		srat_pkg::req_t r;
		r.opcode      = srat_pkg::OP_LOAD;
		r.entry_index = idx;
		r.offset_in   = $urandom;
		case ($urandom_range(0, 9))
			0:       r.entry_mem_base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
			1:       r.entry_mem_base = $urandom_range(0, 4096);
			default: r.entry_mem_base = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0:       r.entry_file_base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
			1:       r.entry_file_base = $urandom_range(0, 4096);
			default: r.entry_file_base = $urandom;
		endcase
		case ($urandom_range(0, 9))
			6:       r.entry_size = 32'h0;
			7:       r.entry_size = 32'hFFFF_FFFF;
			8, 9:    r.entry_size = $urandom;
			default: r.entry_size = $urandom_range(0, 4096);
		endcase
		return r;
	endfunction

	// Mostly translates aimed at a loaded section: its edges, just outside
	// them, or somewhere inside. The rest are loads, wild offsets and the
	// unused opcode.
	function automatic srat_pkg::req_t random_item();
		srat_pkg::req_t r;
		int             pick;
		int             k;
		logic [31:0]    src;
		logic [31:0]    span;
		logic [32:0]    top;
		pick = $urandom_range(0, 19);
		if (pick < 4)
			return random_load(4'($urandom_range(0, srat_pkg::MAX_SECTIONS - 1)));
		if (pick == 4)
			r.opcode = OP_UNUSED;
		else
			r.opcode = $urandom_range(0, 1) ? srat_pkg::OP_MEM_TO_FILE
				: srat_pkg::OP_FILE_TO_MEM;
		r.entry_index     = 4'($urandom);
		r.entry_mem_base  = $urandom;
		r.entry_size      = $urandom;
		r.entry_file_base = $urandom;
		r.offset_in       = $urandom;
		if (pick >= 8) begin
			k    = $urandom_range(0, srat_pkg::MAX_SECTIONS - 1);
			src  = (r.opcode == srat_pkg::OP_FILE_TO_MEM) ? sb.file_base[k]
				: sb.mem_base[k];
			span = sb.sect_size[k];
			top  = {1'b0, src} + {1'b0, span};
			case ($urandom_range(0, 5))
				0: r.offset_in = src;
				1: r.offset_in = top[32] ? 32'hFFFF_FFFF : top[31:0];
				2: r.offset_in = src - 32'd1;
				3: r.offset_in = top[31:0] + 32'd1;
				default: begin
					top = {1'b0, src} + ({1'b0, $urandom} % ({1'b0, span} + 33'd1));
					r.offset_in = top[32] ? 32'hFFFF_FFFF : top[31:0];
				end
			endcase
		end
		return r;
	endfunction

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Count is zero after reset: a translate must miss and pass the offset
		// through, and the unused opcode must vanish without a result.
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, 4'd0, '0, '0, '0, 32'h0000_1234));
		offer(pack_item(OP_UNUSED, 4'hF, '1, '1, '1, '1));

		// Overlapping sections 0 and 2, a full-span section whose top runs past
		// 32 bits, and an empty section at zero whose rebase wraps.
		offer(pack_item(srat_pkg::OP_LOAD, 4'd0, 32'h0000_1000, 32'h0000_0100,
			32'h0000_0400, '0));
		offer(pack_item(srat_pkg::OP_LOAD, 4'd1, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			32'h0000_0000, '0));
		offer(pack_item(srat_pkg::OP_LOAD, 4'd2, 32'h0000_1080, 32'h0000_0010,
			32'h0000_9000, '0));
		offer(pack_item(srat_pkg::OP_LOAD, 4'd3, 32'h0000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, '0));
		write_section_count(5'd4);

		// both range edges, just past each, first match wins, wrap both ways
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_1000));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_1100));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_1101));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_0FFF));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_1085));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'hFFFF_FFFF));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_0000));
		offer(pack_item(srat_pkg::OP_FILE_TO_MEM, '0, '0, '0, '0, 32'h0000_0400));
		offer(pack_item(srat_pkg::OP_FILE_TO_MEM, '0, '0, '0, '0, 32'h0000_0020));
		offer(pack_item(srat_pkg::OP_FILE_TO_MEM, '0, '0, '0, '0, 32'hFFFF_FFFF));

		// with one section live, the empty one at zero drops out
		write_section_count(5'd1);
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_0000));
		offer(pack_item(srat_pkg::OP_MEM_TO_FILE, '0, '0, '0, '0, 32'h0000_1000));

		// Fill the rest of the table before any count can reach it.
		for (int k = 4; k < srat_pkg::MAX_SECTIONS; k++)
			offer(random_load(k[3:0]));

		// Random phases over several counts, including zero, the full table and
		// counts past the table that must saturate.
		foreach (phase_count[p]) begin
			write_section_count(phase_count[p][srat_pkg::COUNT_W-1:0]);
			repeat (55) offer(random_item());
		end

		// Pause for every owed result, then hold the receiver off for a long
		// stretch while items keep coming so that the chain fills and backs up.
		drain_results();
		hold_request = LONG_HOLD;
		repeat (40) send_item(random_item());

		// Last stretch back to back with no stalls.
		quiet = 1'b1;
		write_section_count(5'($urandom_range(0, 31)));
		repeat (40) send_item(random_item());

		drain_results();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
